// File: rtl/hre_pkg.sv
// Shared constants, register codes and types of the Hessian ridge eigenvalue block.
`default_nettype none

package hre_pkg;

  // Field and storage widths.
  localparam int SAMPLE_W    = 16;
  localparam int COORD_W     = 12;
  localparam int FRAME_W     = 13;
  localparam int BORDER_W    = 7;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int LINE_DEPTH  = 4096;
  localparam int HESS_W      = 18;
  localparam int EV_W        = 22;
  localparam int DIR_W       = 16;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 80;
  localparam int M_TUSER_W   = 2;

  // Arithmetic unit sizes.
  localparam int SQRT_IN_W   = 48;
  localparam int SQRT_ROOT_W = 24;
  localparam int DIV_NUM_W   = 38;
  localparam int DIV_DEN_W   = 24;
  localparam int DIV_Q_W     = 15;
  localparam int UNIT_ONE    = 16384;

  // Register stages from input beat to output register.
  localparam int PIPE_LEN = 3 + 3 + SQRT_ROOT_W + 7 + SQRT_ROOT_W + 1 + DIV_Q_W + 1;

  // Reset values of the configuration registers.
  localparam logic [FRAME_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [BORDER_W-1:0] BORDER_SIZE_RST  = 7'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_BORDER_SIZE  = 2'd2
  } cfg_reg_t;

  // Position information that travels with each window centre.
  typedef struct packed {
    logic               in_region;
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
  } meta_t;

endpackage

`default_nettype wire

// File: rtl/hre_front.sv
// Front end: configuration registers, line stores, pixel counters, 3x3 window and second differences.
`default_nettype none

module hre_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                acc,
  input  logic [hre_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                frame_start,
  input  logic                                cfg_we,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [hre_pkg::HESS_W-1:0]   hess_a,
  output logic signed [hre_pkg::HESS_W-1:0]   hess_c,
  output logic signed [hre_pkg::HESS_W-1:0]   hess_d,
  output hre_pkg::meta_t                      meta
);
  import hre_pkg::*;

  logic [FRAME_W-1:0]  frame_width;
  logic [FRAME_W-1:0]  frame_height;
  logic [BORDER_W-1:0] border_size;
  logic [COORD_W-1:0]  column_count;
  logic [COORD_W-1:0]  row_count;
  logic [COORD_W-1:0]  column_count_next;
  logic [COORD_W-1:0]  row_count_next;
  logic [COORD_W-1:0]  col_cur;
  logic [COORD_W-1:0]  row_cur;
  logic [COORD_W:0]    col_inc;
  logic [COORD_W:0]    row_inc;
  logic                x_ok;
  logic                y_ok;
  meta_t               meta_in;

  logic [SAMPLE_W-1:0] upper_mem [LINE_DEPTH];
  logic [SAMPLE_W-1:0] lower_mem [LINE_DEPTH];

  logic                v1;
  logic [COORD_W-1:0]  idx1;
  logic [SAMPLE_W-1:0] rd_up;
  logic [SAMPLE_W-1:0] rd_lo;
  logic                up_fwd;
  logic [SAMPLE_W-1:0] up_fwd_val;
  logic [SAMPLE_W-1:0] s1;
  meta_t               meta1;
  logic [SAMPLE_W-1:0] up_eff;

  logic [SAMPLE_W-1:0]      win [3][3];
  meta_t                    meta2;
  logic signed [HESS_W-1:0] ew [3][3];

  // Position of the incoming pixel, counter advance and region test.
  always_comb begin
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    col_inc = {1'b0, col_cur} + (COORD_W+1)'(1);
    row_inc = {1'b0, row_cur} + (COORD_W+1)'(1);
    if (col_inc >= frame_width || col_inc[COORD_W]) begin
      column_count_next = '0;
      if (row_inc >= frame_height || row_inc[COORD_W]) begin
        row_count_next = '0;
      end else begin
        row_count_next = row_inc[COORD_W-1:0];
      end
    end else begin
      column_count_next = col_inc[COORD_W-1:0];
      row_count_next    = row_cur;
    end
    x_ok = (col_cur > COORD_W'(border_size)) &&
           (({1'b0, col_cur} + FRAME_W'(border_size)) <= frame_width);
    y_ok = (row_cur > COORD_W'(border_size)) &&
           (({1'b0, row_cur} + FRAME_W'(border_size)) <= frame_height);
    meta_in.in_region = x_ok && y_ok;
    meta_in.centre_x  = col_cur - COORD_W'(1);
    meta_in.centre_y  = row_cur - COORD_W'(1);
  end

  // Pixel counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (acc) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      border_size  <= BORDER_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BORDER_SIZE:  border_size  <= cfg_data[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Line stores: lower takes the new sample at once, upper takes the old lower
  // value from the registered read data once it is back.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_up            <= upper_mem[col_cur];
      rd_lo            <= lower_mem[col_cur];
      lower_mem[col_cur] <= sample;
    end
    if (en && v1) begin
      upper_mem[idx1] <= rd_lo;
    end
  end

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= acc;
    end
  end

  // Stage one payload, with forwarding of an upper write that lands on the read edge.
  always_ff @(posedge clk) begin
    if (acc) begin
      idx1       <= col_cur;
      up_fwd     <= v1 && (idx1 == col_cur);
      up_fwd_val <= rd_lo;
      s1         <= sample;
      meta1      <= meta_in;
    end
  end

  assign up_eff = up_fwd ? up_fwd_val : rd_up;

  // Window shifts one column per pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (en && v1) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up_eff;
      win[1][2] <= rd_lo;
      win[2][2] <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta2 <= meta1;
    end
  end

  // Second differences of the window.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ew[r][c] = $signed(HESS_W'(win[r][c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hess_a <= ew[1][0] + ew[1][2] - (ew[1][1] <<< 1);
      hess_c <= ew[0][1] + ew[2][1] - (ew[1][1] <<< 1);
      hess_d <= ew[0][0] + ew[2][2] - ew[2][0] - ew[0][2];
      meta   <= meta2;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hre_sqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder.
`default_nettype none

module hre_sqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [hre_pkg::SQRT_IN_W-1:0]     radicand,
  output logic [hre_pkg::SQRT_ROOT_W-1:0]   root,
  output logic [hre_pkg::SQRT_IN_W-1:0]     remainder
);
  import hre_pkg::*;

  logic [SQRT_IN_W-1:0]   rem_s  [SQRT_ROOT_W];
  logic [SQRT_ROOT_W-1:0] root_s [SQRT_ROOT_W];

  for (genvar s = 0; s < SQRT_ROOT_W; s++) begin : g_stage
    localparam int Bit = SQRT_ROOT_W - 1 - s;
    logic [SQRT_IN_W-1:0]   rem_in;
    logic [SQRT_ROOT_W-1:0] root_in;
    logic [SQRT_IN_W-1:0]   trial;
    logic                   fits;

    if (s == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_s[s-1];
      assign root_in = root_s[s-1];
    end

    // Trial subtrahend (q + 2^bit)^2 - q^2 for the partial root q.
    assign trial = (SQRT_IN_W'(root_in) << (Bit + 1)) | (SQRT_IN_W'(1) << (2 * Bit));
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[s]  <= fits ? rem_in - trial : rem_in;
        root_s[s] <= fits ? (root_in | (SQRT_ROOT_W'(1) << Bit)) : root_in;
      end
    end
  end

  assign root      = root_s[SQRT_ROOT_W-1];
  assign remainder = rem_s[SQRT_ROOT_W-1];

endmodule

`default_nettype wire

// File: rtl/hre_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module hre_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [hre_pkg::DIV_NUM_W-1:0]   num,
  input  logic [hre_pkg::DIV_DEN_W-1:0]   den,
  output logic [hre_pkg::DIV_Q_W-1:0]     quo
);
  import hre_pkg::*;

  logic [DIV_NUM_W-1:0] rem_s [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_s [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_s [DIV_Q_W];

  for (genvar s = 0; s < DIV_Q_W; s++) begin : g_stage
    localparam int Bit = DIV_Q_W - 1 - s;
    logic [DIV_NUM_W-1:0] rem_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_Q_W-1:0]   quo_in;
    logic [DIV_NUM_W-1:0] trial;
    logic                 fits;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_s[s-1];
      assign den_in = den_s[s-1];
      assign quo_in = quo_s[s-1];
    end

    assign trial = DIV_NUM_W'(den_in) << Bit;
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[s] <= fits ? rem_in - trial : rem_in;
        den_s[s] <= den_in;
        quo_s[s] <= fits ? (quo_in | (DIV_Q_W'(1) << Bit)) : quo_in;
      end
    end
  end

  assign quo = quo_s[DIV_Q_W-1];

endmodule

`default_nettype wire

// File: rtl/hessian_ridge_eigen.sv
// Top level: Hessian ridge detector giving the larger eigenvalue and its unit eigenvector.
// Throughput: one pixel per cycle; each stage holds one pixel and the divide and square
// root units produce one bit per stage, so a stalled output freezes the whole pipeline.
// Reset clears the pixel counters, the 3x3 window and the pipeline valid bits, and loads
// the frame size and border registers with 640, 480 and 1; the line stores are not cleared.
`default_nettype none

module hessian_ridge_eigen (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hre_pkg::S_TDATA_W-1:0]       s_tdata,   // [15:0] sample
  input  logic                                s_tuser,   // [0] frame_start
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [11:0] centre_x, [23:12] centre_y, [45:24] eigen_value, [61:46] dir_x,
  // [77:62] dir_y, [79:78] zero
  output logic [hre_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic [hre_pkg::M_TUSER_W-1:0]       m_tuser,   // [0] in_region, [1] degenerate
  input  logic                                cfg_we,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hre_pkg::*;

  typedef struct packed {
    meta_t              meta;
    logic signed [18:0] sum;
    logic signed [17:0] d;
    logic signed [17:0] other;
    logic               sel;
  } eig_t;

  typedef struct packed {
    meta_t            meta;
    logic [EV_W-1:0]  ev;
    logic [23:0]      vx;
    logic [23:0]      vy;
  } vec_t;

  typedef struct packed {
    meta_t            meta;
    logic [EV_W-1:0]  ev;
    logic             sx;
    logic             sy;
    logic             deg;
    logic [22:0]      mx;
    logic [22:0]      my;
  } nrm_t;

  logic                en;
  logic                acc;
  logic [PIPE_LEN-1:0] vpipe;

  logic signed [HESS_W-1:0] hess_a;
  logic signed [HESS_W-1:0] hess_c;
  logic signed [HESS_W-1:0] hess_d;
  meta_t                    front_meta;

  eig_t               eig_in;
  logic signed [18:0] diff_in;
  logic [17:0]        a_mag;
  logic [17:0]        c_mag;
  eig_t               s4_eig;
  logic signed [18:0] s4_diff;
  logic signed [37:0] prod1;
  logic signed [35:0] prod2;
  eig_t               s5_eig;
  logic [36:0]        s5_sq1;
  logic [34:0]        s5_sq2;
  eig_t               s6_eig;
  logic [SQRT_IN_W-1:0] s6_rad;

  eig_t                   sb1 [SQRT_ROOT_W];
  logic [SQRT_ROOT_W-1:0] root1;
  logic [SQRT_IN_W-1:0]   rem1;
  logic [20:0]            rr;
  logic signed [23:0]     l4_c;
  logic [23:0]            l4;
  eig_t                   l4_eig;

  vec_t        vec_in;
  logic [23:0] l4m;
  logic [23:0] four_other;
  logic [23:0] d24;
  vec_t        vec_q;

  nrm_t        n1_in;
  nrm_t        n1_q;
  logic [22:0] m_or;
  logic [4:0]  shift_c;
  nrm_t        n2_q;
  logic [4:0]  shift_q;
  nrm_t        n3_in;
  nrm_t        n3_q;
  logic [45:0] px;
  logic [45:0] py;
  nrm_t        sq_q;
  logic [45:0] sq_px;
  logic [45:0] sq_py;
  nrm_t        sum_q;
  logic [SQRT_IN_W-1:0] n2_sum;

  nrm_t                   sb2 [SQRT_ROOT_W];
  logic [SQRT_ROOT_W-1:0] len;
  logic [SQRT_IN_W-1:0]   rem2;
  logic [DIV_NUM_W-1:0]   num_x;
  logic [DIV_NUM_W-1:0]   num_y;
  logic [DIV_DEN_W-1:0]   num_den;
  nrm_t                   num_q;

  nrm_t               sb3 [DIV_Q_W];
  logic [DIV_Q_W-1:0] q_x;
  logic [DIV_Q_W-1:0] q_y;
  logic [DIV_Q_W-1:0] qc_x;
  logic [DIV_Q_W-1:0] qc_y;
  nrm_t               fin;

  logic               o_in_region;
  logic [COORD_W-1:0] o_cx;
  logic [COORD_W-1:0] o_cy;
  logic [EV_W-1:0]    o_ev;
  logic [DIR_W-1:0]   o_dx;
  logic [DIR_W-1:0]   o_dy;
  logic               o_deg;

  // Whole pipeline moves whenever the output register is free or being drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && en;
  assign m_tvalid = vpipe[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_LEN-2:0], acc};
    end
  end

  hre_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .acc         (acc),
    .sample      (s_tdata[SAMPLE_W-1:0]),
    .frame_start (s_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .hess_a      (hess_a),
    .hess_c      (hess_c),
    .hess_d      (hess_d),
    .meta        (front_meta)
  );

  // Trace, difference and choice of the eigenvector form.
  always_comb begin
    a_mag           = hess_a[17] ? 18'(18'd0 - hess_a) : hess_a;
    c_mag           = hess_c[17] ? 18'(18'd0 - hess_c) : hess_c;
    diff_in         = {hess_a[17], hess_a} - {hess_c[17], hess_c};
    eig_in.meta     = front_meta;
    eig_in.sum      = {hess_a[17], hess_a} + {hess_c[17], hess_c};
    eig_in.d        = hess_d;
    eig_in.sel      = a_mag > c_mag;
    eig_in.other    = (a_mag > c_mag) ? hess_c : hess_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_eig  <= eig_in;
      s4_diff <= diff_in;
    end
  end

  // Squares of the difference and of the cross term.
  always_comb begin
    prod1 = s4_diff * s4_diff;
    prod2 = s4_eig.d * s4_eig.d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_eig <= s4_eig;
      s5_sq1 <= prod1[36:0];
      s5_sq2 <= prod2[34:0];
    end
  end

  // Radicand 4*(a-c)^2 + d^2.
  always_ff @(posedge clk) begin
    if (en) begin
      s6_eig <= s5_eig;
      s6_rad <= SQRT_IN_W'({s5_sq1, 2'b00}) + SQRT_IN_W'(s5_sq2);
    end
  end

  hre_sqrt u_sqrt_rad (
    .clk       (clk),
    .en        (en),
    .radicand  (s6_rad),
    .root      (root1),
    .remainder (rem1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb1[0] <= s6_eig;
      for (int k = 1; k < SQRT_ROOT_W; k++) begin
        sb1[k] <= sb1[k-1];
      end
    end
  end

  // Root rounded to nearest, then four times the larger eigenvalue.
  always_comb begin
    rr   = 21'(root1) + 21'(rem1 > SQRT_IN_W'(root1));
    l4_c = $signed({{4{sb1[SQRT_ROOT_W-1].sum[18]}}, sb1[SQRT_ROOT_W-1].sum, 1'b0}) +
           $signed({3'b000, rr});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l4     <= l4_c;
      l4_eig <= sb1[SQRT_ROOT_W-1];
    end
  end

  // Eigenvector in quarter units and the saturated eigenvalue.
  always_comb begin
    four_other  = {{4{l4_eig.other[17]}}, l4_eig.other, 2'b00};
    d24         = {{6{l4_eig.d[17]}}, l4_eig.d};
    l4m         = l4 - four_other;
    vec_in.meta = l4_eig.meta;
    vec_in.vx   = l4_eig.sel ? l4m : d24;
    vec_in.vy   = l4_eig.sel ? d24 : l4m;
    if (l4[23:21] == {3{l4[21]}}) begin
      vec_in.ev = l4[EV_W-1:0];
    end else begin
      vec_in.ev = l4[23] ? {1'b1, {(EV_W-1){1'b0}}} : {1'b0, {(EV_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_q <= vec_in;
    end
  end

  // Magnitudes and signs.
  always_comb begin
    n1_in.meta = vec_q.meta;
    n1_in.ev   = vec_q.ev;
    n1_in.sx   = vec_q.vx[23];
    n1_in.sy   = vec_q.vy[23];
    n1_in.deg  = (vec_q.vx == '0) && (vec_q.vy == '0);
    n1_in.mx   = vec_q.vx[23] ? 23'(24'd0 - vec_q.vx) : vec_q.vx[22:0];
    n1_in.my   = vec_q.vy[23] ? 23'(24'd0 - vec_q.vy) : vec_q.vy[22:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_q <= n1_in;
    end
  end

  // Left shift that brings the larger magnitude up to at least 2^20.
  always_comb begin
    m_or    = n1_q.mx | n1_q.my;
    shift_c = '0;
    for (int i = 0; i < 20; i++) begin
      if (m_or[i]) begin
        shift_c = 5'(20 - i);
      end
    end
    if (m_or[22:20] != '0) begin
      shift_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_q    <= n1_q;
      shift_q <= shift_c;
    end
  end

  // Scaled magnitudes, all other fields carried along.
  always_comb begin
    n3_in    = n2_q;
    n3_in.mx = 23'(n2_q.mx << shift_q);
    n3_in.my = 23'(n2_q.my << shift_q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_q <= n3_in;
    end
  end

  // Squared length of the scaled vector.
  always_comb begin
    px = n3_q.mx * n3_q.mx;
    py = n3_q.my * n3_q.my;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_q  <= n3_q;
      sq_px <= px;
      sq_py <= py;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q  <= sq_q;
      n2_sum <= SQRT_IN_W'(sq_px) + SQRT_IN_W'(sq_py);
    end
  end

  hre_sqrt u_sqrt_len (
    .clk       (clk),
    .en        (en),
    .radicand  (n2_sum),
    .root      (len),
    .remainder (rem2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb2[0] <= sum_q;
      for (int k = 1; k < SQRT_ROOT_W; k++) begin
        sb2[k] <= sb2[k-1];
      end
    end
  end

  // Numerators with half the length added for rounding; the remainder of the
  // length root is not needed.
  always_ff @(posedge clk) begin
    if (en) begin
      num_x   <= DIV_NUM_W'({sb2[SQRT_ROOT_W-1].mx, 14'b0}) + DIV_NUM_W'(len >> 1) +
                 DIV_NUM_W'(rem2 & '0);
      num_y   <= DIV_NUM_W'({sb2[SQRT_ROOT_W-1].my, 14'b0}) + DIV_NUM_W'(len >> 1);
      num_den <= len;
      num_q   <= sb2[SQRT_ROOT_W-1];
    end
  end

  hre_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (num_x),
    .den (num_den),
    .quo (q_x)
  );

  hre_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (num_y),
    .den (num_den),
    .quo (q_y)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb3[0] <= num_q;
      for (int k = 1; k < DIV_Q_W; k++) begin
        sb3[k] <= sb3[k-1];
      end
    end
  end

  // Clamp, apply signs, zero the direction of degenerate results and blank results outside the region.
  always_comb begin
    fin  = sb3[DIV_Q_W-1];
    qc_x = (q_x > DIV_Q_W'(UNIT_ONE)) ? DIV_Q_W'(UNIT_ONE) : q_x;
    qc_y = (q_y > DIV_Q_W'(UNIT_ONE)) ? DIV_Q_W'(UNIT_ONE) : q_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_in_region <= fin.meta.in_region;
      o_cx        <= fin.meta.centre_x;
      o_cy        <= fin.meta.centre_y;
      if (!fin.meta.in_region) begin
        o_ev  <= '0;
        o_dx  <= '0;
        o_dy  <= '0;
        o_deg <= 1'b0;
      end else if (fin.deg) begin
        o_ev  <= fin.ev;
        o_dx  <= '0;
        o_dy  <= '0;
        o_deg <= 1'b1;
      end else begin
        o_ev  <= fin.ev;
        o_dx  <= fin.sx ? DIR_W'(0) - DIR_W'(qc_x) : DIR_W'(qc_x);
        o_dy  <= fin.sy ? DIR_W'(0) - DIR_W'(qc_y) : DIR_W'(qc_y);
        o_deg <= 1'b0;
      end
    end
  end

  assign m_tdata = {2'b00, o_dy, o_dx, o_ev, o_cy, o_cx};
  assign m_tuser = {o_deg, o_in_region};

endmodule

`default_nettype wire

// File: dv/tb_hessian_ridge_eigen.sv
// Self-checking testbench for the Hessian ridge eigenvalue block with an in-bench predictor.
`default_nettype none

module tb_hessian_ridge_eigen;
  import hre_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = PIPE_LEN + 16;
  localparam int MAX_REPORTS = 40;

  // One expected or observed result beat.
  typedef struct packed {
    logic                   in_region;
    logic [COORD_W-1:0]     centre_x;
    logic [COORD_W-1:0]     centre_y;
    logic [EV_W-1:0]        eigen_value;
    logic [DIR_W-1:0]       dir_x;
    logic [DIR_W-1:0]       dir_y;
    logic                   degenerate;
  } ridge_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;   // [15:0] sample
  logic                   s_tuser;   // [0] frame_start
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;   // [11:0] cx, [23:12] cy, [45:24] eigen, [61:46] dx, [77:62] dy
  logic [M_TUSER_W-1:0]   m_tuser;   // [0] in_region, [1] degenerate
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  hessian_ridge_eigen dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: line stores, window, pixel counters and register copies.
  logic [SAMPLE_W-1:0] upper_line [LINE_DEPTH];
  logic [SAMPLE_W-1:0] lower_line [LINE_DEPTH];
  longint              win [3][3];
  int unsigned         col_cnt, row_cnt;
  int unsigned         width_reg, height_reg, border_reg;

  ridge_beat_t expected_q[$];
  int          errors, reports;
  int          pixels_sent, beats_checked, region_beats, degenerate_beats;
  int          send_idle_pct, recv_idle_pct, hold_cycles;
  longint      cycle_cnt;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Floor square root, bit by bit.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // One Q1.14 component, rounded half away from zero and clamped to one.
  function automatic longint unit_component(longint v, longint unsigned len);
    longint unsigned q;
    q = (longint'(mag(v)) * 16384 + len / 2) / len;
    if (q > UNIT_ONE) q = UNIT_ONE;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Advance the window with one pixel and compute the ridge result it causes.
  function automatic ridge_beat_t ridge_predict(logic [SAMPLE_W-1:0] px, logic fs);
    ridge_beat_t r;
    int unsigned col, row, idx, nxt;
    longint cx, cy, a, c, d, diff, l4, vx, vy, ev, dx, dy;
    longint bx, wx, hy;
    longint unsigned rad, root, len;
    bit inreg, deg;
    ev = 0; dx = 0; dy = 0; deg = 0;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt;
    row = row_cnt;
    idx = col % LINE_DEPTH;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[idx];
    win[1][2] = lower_line[idx];
    win[2][2] = px;
    upper_line[idx] = lower_line[idx];
    lower_line[idx] = px;

    // Region test in signed arithmetic so that column zero gives a negative centre.
    cx = longint'(col) - 1;
    cy = longint'(row) - 1;
    bx = longint'(border_reg);
    wx = longint'(width_reg);
    hy = longint'(height_reg);
    inreg = cx >= bx && cx + bx < wx && cy >= bx && cy + bx < hy;
    if (inreg) begin
      a = win[1][0] + win[1][2] - 2 * win[1][1];
      c = win[0][1] + win[2][1] - 2 * win[1][1];
      d = win[0][0] + win[2][2] - win[2][0] - win[0][2];
      diff = a - c;
      rad = 4 * diff * diff + d * d;
      root = floor_sqrt(rad);
      if (rad - root * root > root) root++;
      l4 = 2 * (a + c) + longint'(root);
      ev = l4;
      if (ev > 2097151) ev = 2097151;
      if (ev < -2097152) ev = -2097152;
      if (mag(a) > mag(c)) begin
        vx = l4 - 4 * c;
        vy = d;
      end else begin
        vx = d;
        vy = l4 - 4 * a;
      end
      if (vx == 0 && vy == 0) begin
        deg = 1;
      end else begin
        while (mag(vx) < (64'd1 << 20) && mag(vy) < (64'd1 << 20)) begin
          vx *= 2;
          vy *= 2;
        end
        len = floor_sqrt(vx * vx + vy * vy);
        dx = unit_component(vx, len);
        dy = unit_component(vy, len);
      end
    end

    // Column and row counters wrap at the frame size or past the coordinate range.
    nxt = col + 1;
    if (nxt >= width_reg || nxt > 4095) begin
      col_cnt = 0;
      nxt = row + 1;
      row_cnt = (nxt >= height_reg || nxt > 4095) ? 0 : nxt;
    end else begin
      col_cnt = nxt;
    end

    r.in_region   = inreg;
    r.centre_x    = COORD_W'(col - 1);
    r.centre_y    = COORD_W'(row - 1);
    r.eigen_value = EV_W'(ev);
    r.dir_x       = DIR_W'(dx);
    r.dir_y       = DIR_W'(dy);
    r.degenerate  = deg;
    return r;
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("tb_hessian_ridge_eigen: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Input beats are sampled mid-cycle; the beat completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_q.insert(expected_q.size(), ridge_predict(s_tdata, s_tuser));
      pixels_sent++;
    end
  end

  // Compare each output beat with the oldest expected result.
  always @(negedge clk) begin
    ridge_beat_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.in_region   = m_tuser[0];
      got.degenerate  = m_tuser[1];
      got.centre_x    = m_tdata[11:0];
      got.centre_y    = m_tdata[23:12];
      got.eigen_value = m_tdata[45:24];
      got.dir_x       = m_tdata[61:46];
      got.dir_y       = m_tdata[77:62];
      if (expected_q.size() == 0) begin
        errors++;
        if (reports++ < MAX_REPORTS)
          $display("%0t: unexpected result beat, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        beats_checked++;
        if (want.in_region) region_beats++;
        if (want.degenerate) degenerate_beats++;
        if (got !== want) begin
          errors++;
          if (reports++ < MAX_REPORTS) begin
            $display("%0t: mismatch at centre (%0d,%0d)", $time, want.centre_x, want.centre_y);
            $display("  expected reg=%0b ev=%0d dx=%0d dy=%0d deg=%0b x=%0d y=%0d",
                     want.in_region, $signed(want.eigen_value), $signed(want.dir_x),
                     $signed(want.dir_y), want.degenerate, want.centre_x, want.centre_y);
            $display("  actual   reg=%0b ev=%0d dx=%0d dy=%0d deg=%0b x=%0d y=%0d",
                     got.in_region, $signed(got.eigen_value), $signed(got.dir_x),
                     $signed(got.dir_y), got.degenerate, got.centre_x, got.centre_y);
          end
        end
      end
    end
  end

  // Offer one pixel beat and return at the edge that takes it.
  task automatic send_pixel(logic [SAMPLE_W-1:0] px, logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tuser  <= fs;
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Random sample biased toward the extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return SAMPLE_W'($urandom_range(255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Send npix pixels of one frame; noise_pct is the chance of a stray frame start.
  task automatic send_frame(int npix, int noise_pct);
    for (int i = 0; i < npix; i++)
      send_pixel(pick_sample(), i == 0 || $urandom_range(999) < noise_pct);
  endtask

  // Wait for every result, then let the pipeline drain before touching registers.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  width_reg  = value & 13'h1FFF;
      REG_FRAME_HEIGHT: height_reg = value & 13'h1FFF;
      REG_BORDER_SIZE:  border_reg = value & 7'h7F;
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned b);
    settle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_BORDER_SIZE, b);
  endtask

  // Reset values: a short run on the default 640-wide frame, columns counting up.
  task automatic test_reset_defaults();
    send_frame(40, 0);
  endtask

  // Hand-built 3x3 frames: flat, column ridge with a diagonal, and a bright spot.
  task automatic test_directed_windows();
    logic [SAMPLE_W-1:0] flat [9], ridge [9], spot [9];
    flat  = '{default: 16'h0000};
    ridge = '{16'hFFFF, 16'hFFFF, 16'h0000,
              16'h0000, 16'hFFFF, 16'h0000,
              16'h0000, 16'hFFFF, 16'hFFFF};
    spot  = '{16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'hFFFF, 16'h0000,
              16'h0000, 16'h0000, 16'h0000};
    set_frame(3, 3, 1);
    for (int i = 0; i < 9; i++) send_pixel(flat[i], i == 0);
    for (int i = 0; i < 9; i++) send_pixel(ridge[i], i == 0);
    for (int i = 0; i < 9; i++) send_pixel(spot[i], i == 0);
  endtask

  // Random small frames, mostly whole, some cut short or restarted mid-frame.
  task automatic test_random_frames(int n_items);
    int unsigned w, h, b, npix;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 9);
      b = $urandom_range(1, 3);
      set_frame(w, h, b);
      npix = w * h * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) npix = $urandom_range(1, w * h);
      send_frame(npix, $urandom_range(3) == 0 ? 20 : 0);
      sent += npix;
    end
  endtask

  // Widths below three: the row counter advances every pixel or every other pixel.
  task automatic test_narrow_frames();
    set_frame(1, 4, 1);
    send_frame(8, 0);
    set_frame(2, 3, 1);
    send_frame(8, 0);
  endtask

  // Largest height: a few rows of a tall narrow frame, then a fresh frame.
  task automatic test_tall_frame();
    set_frame(3, 4096, 1);
    send_frame(3 * 6, 0);
    send_frame(3 * 4, 0);
  endtask

  // Widest border that still leaves a region: the first pixels of a large frame all lie outside it.
  task automatic test_wide_border();
    set_frame(130, 131, 64);
    send_frame(60, 0);
  endtask

  // Long receiver hold-off while pixels keep coming, so the input stalls.
  task automatic test_backpressure();
    set_frame(16, 8, 2);
    hold_cycles <= 300;
    send_frame(16 * 8, 0);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    cfg_we = 1'b0; cfg_index = REG_FRAME_WIDTH; cfg_data = '0;
    errors = 0; reports = 0;
    cycle_cnt <= 0; hold_cycles <= 0;
    pixels_sent = 0; beats_checked = 0; region_beats = 0; degenerate_beats = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = 0;
    col_cnt = 0; row_cnt = 0;
    width_reg = FRAME_WIDTH_RST; height_reg = FRAME_HEIGHT_RST; border_reg = BORDER_SIZE_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 34; recv_idle_pct = 48;
    test_reset_defaults();
    test_directed_windows();
    test_random_frames(130);
    test_backpressure();

    send_idle_pct = 48; recv_idle_pct = 34;
    test_random_frames(130);
    test_tall_frame();

    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_frames(130);
    test_narrow_frames();
    test_wide_border();
    settle();

    $display("Run covered %0d pixels and %0d result beats (%0d in region, %0d degenerate),",
             pixels_sent, beats_checked, region_beats, degenerate_beats);
    $display("with small random frames, widths of one and two, a 4096-row frame and border 64.");
    if (errors == 0) begin
      $display("tb_hessian_ridge_eigen: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_hessian_ridge_eigen: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
